### design/cmmr_pkg.sv
// ----------------------------------------------------------------------------
// Centered moving mean removal: shared package
// Transaction types, field widths and the result kind codes.
// ----------------------------------------------------------------------------
package cmmr_pkg;

	// field widths
	localparam int SAMPLE_BITS = 16;
	localparam int VALUE_BITS  = SAMPLE_BITS + 1;
	localparam int WL_BITS     = 7;
	localparam int KIND_BITS   = 2;

	// window length after reset
	localparam logic [WL_BITS-1:0] WL_RESET = 7'd16;

	// input commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// result kinds
	localparam logic [KIND_BITS-1:0] KIND_VALUE     = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_ZERO_FILL = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_NO_VALID  = 2'd2;

	// input transaction
	typedef struct packed {
		logic                          command;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          sample_valid;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [KIND_BITS-1:0]         kind;
		logic                         last;
	} out_item_t;

endpackage

### design/cmmr_ram.sv
// ----------------------------------------------------------------------------
// Centered moving mean removal: generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module cmmr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/cmmr_div.sv
// ----------------------------------------------------------------------------
// Centered moving mean removal: iterative divider
// Signed dividend over unsigned divisor, quotient truncated toward zero.
// Restoring algorithm, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmmr_div #(
	parameter int DIVIDEND_W = 23,
	parameter int DIVISOR_W  = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]         divisor,
	output logic                         busy,
	output logic signed [DIVIDEND_W-1:0] quotient
);

	localparam int MAG_W = DIVIDEND_W - 1;
	localparam int CNT_W = $clog2(MAG_W + 1);

	logic                         busy_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [DIVISOR_W-1:0]         rem_q;
	logic [MAG_W-1:0]             mag_q;
	logic                         neg_q;
	logic signed [DIVIDEND_W-1:0] quo_q;

	logic [DIVIDEND_W-1:0] abs_dvd;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W+1:0]  trial;
	logic                  ge;
	logic [MAG_W-1:0]      mag_nxt;
	logic [DIVIDEND_W-1:0] mag_ext;

	// one restoring step
	always_comb begin
		abs_dvd = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
		shifted = {rem_q, mag_q[MAG_W-1]};
		trial   = {1'b0, shifted} - {2'b00, divisor};
		ge      = !trial[DIVISOR_W+1];
		mag_nxt = {mag_q[MAG_W-2:0], ge};
		mag_ext = {1'b0, mag_nxt};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			mag_q <= abs_dvd[MAG_W-1:0];
			neg_q <= dividend[DIVIDEND_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			mag_q <= mag_nxt;
			if (cnt_q == CNT_W'(1)) begin
				quo_q <= neg_q ? DIVIDEND_W'(-mag_ext) : DIVIDEND_W'(mag_ext);
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### design/centered_moving_mean_removal.sv
// ----------------------------------------------------------------------------
// Centered moving mean removal
// High-pass filter: window-center sample minus the mean of the valid samples.
// ----------------------------------------------------------------------------
// Samples are taken one at a time. While the window fills, a sample gives no
// result. After that each sample runs the shared bit-serial divider that forms
// the mean (SAMPLE_BITS + clog2(MAX_WINDOW) quotient bits, 22 at defaults).
// The first sample after the window fills runs the divider twice and emits
// W/2 extra results, each a RAM read, then an output. A flush runs the divider
// and emits W/2 results, then restarts the stream. Output stall holds the
// sequencer until the output slot is free. The effective window length is the
// register rounded up to even and clamped to 4..TOP (MAX_WINDOW rounded down
// to even); writing the register restarts the stream.
module centered_moving_mean_removal #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  cmmr_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cmmr_pkg::out_item_t           out_data,
	input  logic                          cfg_we,
	input  logic [cmmr_pkg::WL_BITS-1:0]  cfg_wdata
);

	localparam int SB     = cmmr_pkg::SAMPLE_BITS;
	localparam int VB     = cmmr_pkg::VALUE_BITS;
	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SEEN_W = $clog2(MAX_WINDOW + 2);
	localparam int IW     = CNT_W + 1;
	localparam int SUM_W  = SB + $clog2(MAX_WINDOW) + 1;
	localparam int TOP    = MAX_WINDOW & ~1;
	localparam int WW     = cmmr_pkg::WL_BITS + 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_OLD_RD = 3'd1;
	localparam logic [2:0] ST_OLD_UP = 3'd2;
	localparam logic [2:0] ST_START  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_EM_RD  = 3'd5;
	localparam logic [2:0] ST_EM_OUT = 3'd6;

	// what the current emit run belongs to
	localparam logic [1:0] PH_FLUSH  = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_STEADY = 2'd2;

	logic [2:0]                  state_q;
	logic [1:0]                  phase_q;
	logic [cmmr_pkg::WL_BITS-1:0] wl_q;
	logic [PTR_W-1:0]            wp_q;
	logic [PTR_W-1:0]            idx_q;
	logic [PTR_W-1:0]            left_q;
	logic [SEEN_W-1:0]           seen_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]            count_q;
	logic [MAX_WINDOW-1:0]       valid_q;
	logic [SB-1:0]               samp_q;
	logic                        ok_q;
	logic                        out_valid_q;
	cmmr_pkg::out_item_t         out_q;

	logic [WW-1:0]           w_rnd;
	logic [CNT_W-1:0]        w_eff;
	logic [PTR_W-1:0]        half;
	logic [IW-1:0]           cp_sum;
	logic [PTR_W-1:0]        cp;
	logic [PTR_W-1:0]        wp_nxt;
	logic [PTR_W-1:0]        idx_nxt;
	logic                    accept;
	logic                    filling;
	logic                    slot_free;
	logic                    run_done;
	logic                    clear_stream;
	logic                    div_start;
	logic                    div_busy;
	logic signed [SUM_W-1:0] quo;
	logic [SB-1:0]           ram_rdata;
	logic                    ram_we;
	logic [SB-1:0]           ram_wdata;
	logic                    ram_re;
	logic [PTR_W-1:0]        ram_raddr;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] new_ext;
	logic signed [SUM_W-1:0] in_ext;
	logic signed [SUM_W-1:0] sum_upd;
	logic [CNT_W-1:0]        cnt_dec;
	logic [CNT_W-1:0]        cnt_upd;
	logic signed [VB-1:0]    samp_ext;
	logic signed [VB-1:0]    mean_v;
	cmmr_pkg::out_item_t     res;

	// effective window: round up to even, clamp to 4..TOP
	always_comb begin
		w_rnd = ({1'b0, wl_q} + WW'(1)) & ~WW'(1);
		if (w_rnd < WW'(4)) begin
			w_rnd = WW'(4);
		end else if (w_rnd > WW'(TOP)) begin
			w_rnd = WW'(TOP);
		end
		w_eff = CNT_W'(w_rnd);
		half  = PTR_W'(w_eff >> 1);
	end

	// center pointer trails the write pointer by half a window
	always_comb begin
		cp_sum  = IW'(wp_q) + IW'(half);
		cp      = (cp_sum >= IW'(w_eff)) ? PTR_W'(cp_sum - IW'(w_eff)) : PTR_W'(cp_sum);
		wp_nxt  = (IW'(wp_q) + IW'(1) == IW'(w_eff)) ? '0 : wp_q + 1'b1;
		idx_nxt = (IW'(idx_q) + IW'(1) == IW'(w_eff)) ? '0 : idx_q + 1'b1;
	end

	// handshake and sequencing conditions
	always_comb begin
		accept    = (state_q == ST_IDLE) && in_valid && !cfg_we;
		filling   = IW'(seen_q) < IW'(w_eff);
		slot_free = !out_valid_q || !out_stall;
		run_done  = (state_q == ST_EM_OUT) && slot_free && (left_q == PTR_W'(1));
		clear_stream = cfg_we || (run_done && (phase_q == PH_FLUSH));
		div_start = (state_q == ST_START);
	end

	// sum and count update for a steady-state sample
	always_comb begin
		old_ext = SUM_W'(signed'(ram_rdata));
		new_ext = SUM_W'(signed'(samp_q));
		in_ext  = SUM_W'(signed'(in_data.sample));
		sum_upd = sum_q;
		cnt_dec = count_q;
		if (valid_q[wp_q]) begin
			sum_upd = sum_upd - old_ext;
			if (count_q != '0) begin
				cnt_dec = count_q - 1'b1;
			end
		end
		cnt_upd = cnt_dec;
		if (ok_q) begin
			sum_upd = sum_upd + new_ext;
			if (cnt_dec < w_eff) begin
				cnt_upd = cnt_dec + 1'b1;
			end
		end
	end

	// result formation from the entry just read
	always_comb begin
		samp_ext = VB'(signed'(ram_rdata));
		mean_v   = quo[VB-1:0];
		res.last = (left_q == PTR_W'(1)) && (phase_q != PH_FIRST);
		if (count_q == '0) begin
			res.value = '0;
			res.kind  = cmmr_pkg::KIND_NO_VALID;
		end else if ((quo == '0) || !valid_q[idx_q]) begin
			res.value = '0;
			res.kind  = cmmr_pkg::KIND_ZERO_FILL;
		end else begin
			res.value = samp_ext - mean_v;
			res.kind  = cmmr_pkg::KIND_VALUE;
		end
	end

	// ring store port control
	always_comb begin
		ram_we    = (accept && (in_data.command == cmmr_pkg::CMD_SAMPLE) && filling)
			|| (run_done && (phase_q == PH_STEADY));
		ram_wdata = (state_q == ST_IDLE) ? in_data.sample : samp_q;
		ram_re    = (state_q == ST_OLD_RD) || (state_q == ST_EM_RD);
		ram_raddr = (state_q == ST_OLD_RD) ? wp_q : idx_q;
	end

	cmmr_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cmmr_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	// sequencer and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_FLUSH;
			wl_q    <= cmmr_pkg::WL_RESET;
			wp_q    <= '0;
			idx_q   <= '0;
			left_q  <= '0;
			seen_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
			valid_q <= '0;
		end else begin
			if (cfg_we) begin
				wl_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.command == cmmr_pkg::CMD_FLUSH) begin
							phase_q <= PH_FLUSH;
							// the center pointer holds at half a window until the window fills
							idx_q   <= filling ? half : cp;
							left_q  <= half;
							state_q <= ST_START;
						end else if (filling) begin
							valid_q[wp_q] <= in_data.sample_valid;
							if (in_data.sample_valid) begin
								sum_q   <= sum_q + in_ext;
								count_q <= count_q + 1'b1;
							end
							wp_q   <= wp_nxt;
							seen_q <= seen_q + 1'b1;
						end else if (IW'(seen_q) == IW'(w_eff)) begin
							seen_q  <= seen_q + 1'b1;
							phase_q <= PH_FIRST;
							idx_q   <= '0;
							left_q  <= half;
							state_q <= ST_START;
						end else begin
							phase_q <= PH_STEADY;
							state_q <= ST_OLD_RD;
						end
					end
				end
				ST_OLD_RD: begin
					state_q <= ST_OLD_UP;
				end
				ST_OLD_UP: begin
					sum_q   <= sum_upd;
					count_q <= cnt_upd;
					idx_q   <= cp;
					left_q  <= PTR_W'(1);
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_EM_RD;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_OUT;
				end
				ST_EM_OUT: begin
					if (slot_free) begin
						idx_q  <= idx_nxt;
						left_q <= left_q - 1'b1;
						if (left_q != PTR_W'(1)) begin
							state_q <= ST_EM_RD;
						end else begin
							case (phase_q)
								PH_FIRST: begin
									phase_q <= PH_STEADY;
									state_q <= ST_OLD_RD;
								end
								PH_STEADY: begin
									valid_q[wp_q] <= ok_q;
									wp_q          <= wp_nxt;
									state_q       <= ST_IDLE;
								end
								default: begin
									state_q <= ST_IDLE;
								end
							endcase
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// restart the stream on flush end or window change
			if (clear_stream) begin
				wp_q    <= '0;
				seen_q  <= '0;
				sum_q   <= '0;
				count_q <= '0;
				valid_q <= '0;
			end
		end
	end

	// held sample of the transaction in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q <= in_data.sample;
			ok_q   <= in_data.sample_valid;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EM_OUT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EM_OUT) && slot_free) begin
			out_q <= res;
		end
	end

	// a window length write holds off the input for that cycle
	assign in_stall  = (state_q != ST_IDLE) || cfg_we;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= w_eff)
		else $error("valid count exceeds the window");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sum_q == '0))
		else $error("running sum nonzero with no valid samples");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		IW'(wp_q) < IW'(w_eff))
		else $error("write pointer outside the window");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_busy)
		else $error("divider running while the sequencer is idle");
`endif

endmodule
